@@ hdl/dstrf_pkg.sv @@
`default_nettype none
package dstrf_pkg;

  localparam int WINDOW_DEPTH_DEFAULT = 10;

  localparam logic [31:0] MPT_RESET   = 32'd20150956;
  localparam logic [30:0] GATE_RESET  = 31'd1310720;
  localparam logic [7:0]  LIMIT_RESET = 8'd20;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_METERS_PER_TICK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GATE_DISTANCE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT     = 2'd2;

  localparam int TIME_W      = 32;
  localparam int OFFSET_W    = 16;
  localparam int DIST_W      = 32;
  localparam int MPT_W       = 32;
  localparam int OFFSET_FRAC = 26;
  localparam int SCALE_SHIFT = 43;

  // n = (ri - rr) * 2^26 + rr * offset, magnitude below 2^59
  localparam int N_W   = 60;
  localparam int MAG_W = N_W - 1;
  localparam int P1_W  = TIME_W + OFFSET_W;
  localparam int P2_W  = MAG_W + MPT_W;
  localparam int Q_W   = P2_W - SCALE_SHIFT + 1;

  localparam int IN_TDATA_W  = 4 * TIME_W + OFFSET_W;
  localparam int OUT_TDATA_W = 40;

endpackage
`default_nettype wire

@@ hdl/dstrf_smul.sv @@
`default_nettype none
module dstrf_smul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            busy,
  output logic [AW+BW-1:0] p
);

  localparam int CNTW = $clog2(BW + 1);

  logic [AW-1:0]   a_q;
  logic [AW-1:0]   hi;
  logic [BW-1:0]   lo;
  logic [CNTW-1:0] cnt;
  logic [AW:0]     acc;

  assign busy = (cnt != '0);
  assign acc  = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : {(AW + 1){1'b0}});
  assign p    = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // one multiplier bit per cycle, partial product shifts right into lo
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= acc[AW:1];
      lo <= {acc[0], lo[BW-1:1]};
    end
  end

endmodule
`default_nettype wire

@@ hdl/dstrf_sdiv.sv @@
`default_nettype none
module dstrf_sdiv #(
  parameter int DW = 36,
  parameter int NW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] a,
  input  logic [NW-1:0] d,
  output logic          busy,
  output logic [DW-1:0] q
);

  localparam int CNTW = $clog2(DW + 1);

  logic [NW-1:0]   rem;
  logic [NW-1:0]   d_q;
  logic [DW-1:0]   qa;
  logic [CNTW-1:0] cnt;
  logic [NW:0]     sh;
  logic [NW:0]     sub;
  logic            ge;

  assign busy = (cnt != '0);
  assign sh   = {rem, qa[DW-1]};
  assign ge   = (sh >= {1'b0, d_q});
  assign sub  = sh - {1'b0, d_q};
  assign q    = qa;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      d_q <= d;
      qa  <= a;
    end else if (busy) begin
      rem <= ge ? sub[NW-1:0] : sh[NW-1:0];
      qa  <= {qa[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ hdl/ds_twr_range_filter.sv @@
// flow: one exchange at a time; s_tready is high only in the idle state, so a new
//   input transaction is taken only after the previous result is placed on m_tdata
// the bit-serial multipliers (16 and 32 steps) and the bit-serial mean divider set the
//   processing time; a rejected sample skips the mean divider
// reset: synchronous, clears window count, last value, error count and sum;
//   registers return to their defaults, window contents stay undefined
`default_nettype none
module ds_twr_range_filter #(
  parameter int WINDOW_DEPTH = dstrf_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // poll_sent_time, reply_seen_time, poll_seen_time, reply_sent_time, clock_offset
  input  logic [dstrf_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // filtered_distance, samples_held, zero fill
  output logic [dstrf_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // rejected
  output logic                                  m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dstrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                           cfg_data
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int SW = 32 + $clog2(WINDOW_DEPTH);
  localparam int NW = dstrf_pkg::N_W;
  localparam int MW = dstrf_pkg::MAG_W;
  localparam int QW = dstrf_pkg::Q_W;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DELTA  = 16'h0002,
    S_PREP   = 16'h0004,
    S_MUL1   = 16'h0008,
    S_NSGN   = 16'h0010,
    S_NSUM   = 16'h0020,
    S_NABS   = 16'h0040,
    S_MUL2   = 16'h0080,
    S_ROUND  = 16'h0100,
    S_SAT    = 16'h0200,
    S_GATE   = 16'h0400,
    S_UPD    = 16'h0800,
    S_SABS   = 16'h1000,
    S_DSTART = 16'h2000,
    S_DIV    = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state;

  logic [31:0] mpt;
  logic [30:0] gate;
  logic [7:0]  limit;

  logic [31:0]        t_ps, t_rs, t_pr, t_rt;
  logic signed [15:0] off_q;
  logic signed [31:0] ri, rr;
  logic signed [32:0] d;
  logic               neg1, neg2;
  logic signed [NW-1:0] t_prod, n_val;
  logic [QW-1:0]      q_r;
  logic signed [31:0] meas, last, old;
  logic signed [32:0] diff, delta;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]      smag;
  logic               sneg;
  logic [CW-1:0]      count;
  logic [PW-1:0]      wp;
  logic [7:0]         err;
  logic               rej;

  logic signed [31:0] win [WINDOW_DEPTH];

  logic [31:0]                   m1_a;
  logic [15:0]                   m1_b;
  logic                          m1_busy;
  logic [dstrf_pkg::P1_W-1:0]    p1;
  logic [MW-1:0]                 m2_a;
  logic                          m2_busy;
  logic [dstrf_pkg::P2_W-1:0]    p2;
  logic [SW-1:0]                 dv_a;
  logic                          dv_busy;
  logic [SW-1:0]                 dv_q;

  logic               full;
  logic               pass;
  logic               wr_en;
  logic [8:0]         err_inc;
  logic signed [32:0] gate_s;
  logic [PW-1:0]      wp_next;
  logic signed [31:0] result;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign m1_a = rr[31] ? 32'(-rr) : 32'(rr);
  assign m1_b = off_q[15] ? 16'(-off_q) : 16'(off_q);
  assign m2_a = n_val[NW-1] ? MW'(-n_val) : MW'(n_val);
  assign dv_a = smag + SW'(count >> 1);

  always_comb begin
    full    = (count == CW'(WINDOW_DEPTH));
    gate_s  = $signed({2'b00, gate});
    pass    = (diff < gate_s) && (-diff < gate_s);
    wr_en   = (state == S_UPD) && (!full || pass);
    err_inc = {1'b0, err} + 9'd1;
    wp_next = (wp == PW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
    result  = rej ? last : 32'(SW'(0) - dv_q);
    if (!rej && !sneg) begin
      result = 32'(dv_q);
    end
  end

  dstrf_smul #(.AW(32), .BW(16)) u_mul_off (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PREP),
    .a     (m1_a),
    .b     (m1_b),
    .busy  (m1_busy),
    .p     (p1)
  );

  dstrf_smul #(.AW(MW), .BW(dstrf_pkg::MPT_W)) u_mul_scale (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_NABS),
    .a     (m2_a),
    .b     (mpt),
    .busy  (m2_busy),
    .p     (p2)
  );

  dstrf_sdiv #(.DW(SW), .NW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .a     (dv_a),
    .d     (count),
    .busy  (dv_busy),
    .q     (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt   <= dstrf_pkg::MPT_RESET;
      gate  <= dstrf_pkg::GATE_RESET;
      limit <= dstrf_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dstrf_pkg::REG_METERS_PER_TICK: mpt   <= cfg_data;
        dstrf_pkg::REG_GATE_DISTANCE:   gate  <= cfg_data[30:0];
        dstrf_pkg::REG_ERROR_LIMIT:     limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // window storage, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win[wp] <= meas;
    end
    old <= win[wp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wp       <= '0;
      last     <= '0;
      err      <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DELTA;
          end
        end
        S_DELTA:  state <= S_PREP;
        S_PREP:   state <= S_MUL1;
        S_MUL1: begin
          if (!m1_busy) begin
            state <= S_NSGN;
          end
        end
        S_NSGN:   state <= S_NSUM;
        S_NSUM:   state <= S_NABS;
        S_NABS:   state <= S_MUL2;
        S_MUL2: begin
          if (!m2_busy) begin
            state <= S_ROUND;
          end
        end
        S_ROUND:  state <= S_SAT;
        S_SAT:    state <= S_GATE;
        S_GATE:   state <= S_UPD;
        S_UPD: begin
          if (!full) begin
            count <= count + 1'b1;
            wp    <= wp_next;
            sum   <= sum + SW'(meas);
            state <= S_SABS;
          end else if (pass) begin
            wp    <= wp_next;
            sum   <= sum + SW'(delta);
            err   <= '0;
            last  <= meas;
            state <= S_SABS;
          end else begin
            state <= S_DONE;
            if (err_inc > {1'b0, limit}) begin
              err   <= '0;
              count <= '0;
              wp    <= '0;
              sum   <= '0;
            end else begin
              err <= err_inc[7:0];
            end
          end
        end
        S_SABS:   state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (!dv_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        t_ps  <= s_tdata[31:0];
        t_rs  <= s_tdata[63:32];
        t_pr  <= s_tdata[95:64];
        t_rt  <= s_tdata[127:96];
        off_q <= s_tdata[143:128];
      end
      S_DELTA: begin
        ri <= t_rs - t_ps;
        rr <= t_rt - t_pr;
      end
      S_PREP: begin
        d    <= 33'(ri) - 33'(rr);
        neg1 <= rr[31] ^ off_q[15];
      end
      S_NSGN:  t_prod <= neg1 ? -NW'(p1) : NW'(p1);
      S_NSUM:  n_val <= (NW'(d) <<< dstrf_pkg::OFFSET_FRAC) + t_prod;
      S_NABS:  neg2 <= n_val[NW-1];
      S_ROUND: begin
        q_r <= QW'(p2[dstrf_pkg::P2_W-1:dstrf_pkg::SCALE_SHIFT])
             + QW'(p2[dstrf_pkg::SCALE_SHIFT-1]);
      end
      S_SAT: begin
        if (neg2) begin
          meas <= (q_r >= QW'(33'h080000000)) ? 32'sh80000000 : 32'(-q_r[31:0]);
        end else begin
          meas <= (q_r > QW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(q_r[31:0]);
        end
      end
      S_GATE: begin
        diff  <= 33'(meas) - 33'(last);
        delta <= 33'(meas) - 33'(old);
      end
      S_UPD:  rej <= full && !pass;
      S_SABS: begin
        smag <= sum[SW-1] ? SW'(-sum) : SW'(sum);
        sneg <= sum[SW-1];
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {4'b0000, 4'(count), result};
          m_tuser <= rej;
        end
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(WINDOW_DEPTH))
    else $error("window count beyond depth");

  a_sum_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (sum == '0))
    else $error("running sum not cleared with empty window");

  a_mul_state: assert property (@(posedge clk) disable iff (rst)
    (m1_busy |-> state == S_MUL1) and (m2_busy |-> state == S_MUL2))
    else $error("multiplier busy outside its state");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    dv_busy |-> state == S_DIV)
    else $error("divider busy outside its state");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_DELTA)
    else $error("accepted transaction not started");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
module tb;

  localparam int DEPTH        = dstrf_pkg::WINDOW_DEPTH_DEFAULT;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 150;
  localparam int REPORT_LINES = 100;

  // field order puts poll_sent in the lowest bits, as on s_tdata
  typedef struct packed {
    logic [15:0] offset;
    logic [31:0] reply_sent;
    logic [31:0] poll_seen;
    logic [31:0] reply_seen;
    logic [31:0] poll_sent;
  } exchange_t;

  typedef struct packed {
    logic [3:0]         held;
    logic               rejected;
    logic signed [31:0] distance;
  } ranging_result_t;

  typedef struct {
    bit              is_setting;
    bit              typed;
    exchange_t       x;
    ranging_result_t want;
    logic [31:0]     mpt;
    logic [31:0]     gate;
    logic [31:0]     limit;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [dstrf_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [dstrf_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dstrf_pkg::CFG_INDEX_W-1:0] cfg_index = dstrf_pkg::REG_METERS_PER_TICK;
  logic [31:0] cfg_data = '0;

  ds_twr_range_filter dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] win_store [DEPTH];
  int unsigned        win_fill;
  logic signed [31:0] last_kept;
  int unsigned        reject_run;
  logic [31:0]        cfg_mpt;
  logic [30:0]        cfg_gate;
  logic [7:0]         cfg_limit;

  ranging_result_t expected_results[$];
  ranging_result_t oldest;
  int mismatches, items_sent, results_checked, rejections_seen, restarts_seen;
  int settings_applied;
  int track_ticks = 2131;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int holds_asked, holds_served, rx_stall, quiet_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < REPORT_LINES)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] tick_distance(exchange_t x);
    logic signed [31:0] ri, rr;
    longint n;
    logic [63:0] mag;
    logic [127:0] prod, q;
    ri = x.reply_seen - x.poll_sent;
    rr = x.reply_sent - x.poll_seen;
    n = (longint'(ri) - longint'(rr)) * 64'sd67108864 + longint'(rr) * longint'($signed(x.offset));
    mag = (n < 0) ? -n : n;
    prod = {64'd0, mag} * {96'd0, cfg_mpt} + (128'd1 << 42);
    q = prod >> 43;
    if (n < 0) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic signed [31:0] rounded_average(longint total, int unsigned count);
    logic [63:0] mag, q;
    mag = (total < 0) ? -total : total;
    q = (mag + count / 2) / count;
    return (total < 0) ? -q[31:0] : q[31:0];
  endfunction

  function automatic ranging_result_t predict_range(exchange_t x);
    ranging_result_t r;
    logic signed [31:0] d;
    longint total, jump;
    int i;
    d = tick_distance(x);
    total = 0;
    r.rejected = 1'b0;
    if (win_fill < DEPTH) begin
      win_store[win_fill] = d;
      win_fill++;
      for (i = 0; i < win_fill; i++) total += win_store[i];
      r.distance = rounded_average(total, win_fill);
    end else begin
      jump = longint'(d) - longint'(last_kept);
      if (jump < 0) jump = -jump;
      if (jump < longint'(cfg_gate)) begin
        reject_run = 0;
        for (i = 0; i < DEPTH - 1; i++) win_store[i] = win_store[i + 1];
        win_store[DEPTH - 1] = d;
        for (i = 0; i < DEPTH; i++) total += win_store[i];
        last_kept = d;
        r.distance = rounded_average(total, DEPTH);
      end else begin
        r.distance = last_kept;
        r.rejected = 1'b1;
        reject_run++;
        if (reject_run > cfg_limit) begin
          reject_run = 0;
          win_fill = 0;
        end
      end
    end
    r.held = win_fill[3:0];
    return r;
  endfunction

  function automatic exchange_t exchange(logic [31:0] poll_sent, logic [31:0] ri,
                                         logic [31:0] poll_seen, logic [31:0] rr,
                                         logic [15:0] offset);
    exchange_t x;
    x.poll_sent  = poll_sent;
    x.reply_seen = poll_sent + ri;
    x.poll_seen  = poll_seen;
    x.reply_sent = poll_seen + rr;
    x.offset     = offset;
    return x;
  endfunction

  // mostly exchanges around a drifting flight time, some outliers and pure noise
  function automatic exchange_t random_exchange();
    exchange_t x;
    int unsigned roll, rr;
    int flight;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0)
      track_ticks = track_ticks + int'($urandom_range(0, 16000)) - 8000;
    else
      track_ticks = track_ticks + int'($urandom_range(0, 6)) - 3;
    if (track_ticks < 0) track_ticks = 0;
    x.poll_sent = $urandom;
    x.poll_seen = $urandom;
    x.offset = 16'($urandom);
    if (roll < 12) begin
      x.reply_seen = $urandom;
      x.reply_sent = $urandom;
    end else begin
      rr = (roll < 20) ? $urandom : $urandom_range(0, 1 << 18);
      if (roll < 30) flight = int'($urandom_range(0, 400000)) - 100000;
      else flight = track_ticks + int'($urandom_range(0, 40)) - 20;
      x.reply_sent = x.poll_seen + rr;
      x.reply_seen = x.poll_sent + rr + 2 * flight;
    end
    return x;
  endfunction

  function automatic table_row_t item_row(exchange_t x);
    table_row_t row;
    row = '{default: '0};
    row.x = x;
    return row;
  endfunction

  function automatic table_row_t known_row(exchange_t x, ranging_result_t want);
    table_row_t row;
    row = item_row(x);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic table_row_t settings_row(logic [31:0] mpt, logic [31:0] gate,
                                              logic [31:0] limit);
    table_row_t row;
    row = '{default: '0};
    row.is_setting = 1'b1;
    row.mpt = mpt;
    row.gate = gate;
    row.limit = limit;
    return row;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic push_register(input logic [dstrf_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [31:0] mpt, input logic [31:0] gate,
                                input logic [31:0] limit);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    push_register(dstrf_pkg::REG_METERS_PER_TICK, mpt);
    push_register(dstrf_pkg::REG_GATE_DISTANCE, gate);
    push_register(dstrf_pkg::REG_ERROR_LIMIT, limit);
    cfg_valid <= 1'b0;
    cfg_mpt = mpt;
    cfg_gate = gate[30:0];
    cfg_limit = limit[7:0];
    settings_applied++;
  endtask

  task automatic send_item(input exchange_t x, input bit typed, input ranging_result_t want);
    ranging_result_t prediction;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    do @(posedge clk); while (!s_tready);
    prediction = predict_range(x);
    expected_results.push_back(typed ? want : prediction);
    items_sent++;
  endtask

  task automatic run_phase(input logic [31:0] mpt, input logic [31:0] gate,
                           input logic [31:0] limit, input int count, input bit squeeze);
    int k;
    apply_settings(mpt, gate, limit);
    if (squeeze) holds_asked <= holds_asked + 1;
    for (k = 0; k < count; k++) send_item(random_exchange(), 1'b0, '0);
  endtask

  // receiver: random stall bursts, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      rx_stall <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
      rx_stall <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (m_tuser) rejections_seen++;
      if (m_tuser && m_tdata[35:32] == 4'd0) restarts_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, distance", $signed(m_tdata[31:0]), 0);
      end else begin
        oldest = expected_results.pop_front();
        if (m_tdata[31:0] !== oldest.distance)
          report_mismatch("filtered_distance", $signed(m_tdata[31:0]), oldest.distance);
        if (m_tuser !== oldest.rejected)
          report_mismatch("rejected", m_tuser, oldest.rejected);
        if (m_tdata[35:32] !== oldest.held)
          report_mismatch("samples_held", m_tdata[35:32], oldest.held);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("stalled for %0d cycles with %0d results pending", quiet_cycles,
             expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    table_row_t directed[$];
    int p;
    cfg_mpt = dstrf_pkg::MPT_RESET;
    cfg_gate = dstrf_pkg::GATE_RESET;
    cfg_limit = dstrf_pkg::LIMIT_RESET;
    win_fill = 0;
    last_kept = 0;
    reject_run = 0;

    // zeros, then all ones with offset -1: both give a zero distance
    directed.push_back(known_row(exchange(32'h0, 32'h0, 32'h0, 32'h0, 16'h0),
                                 '{held: 4'd1, rejected: 1'b0, distance: 32'sd0}));
    directed.push_back(known_row(exchange(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF),
                                 '{held: 4'd2, rejected: 1'b0, distance: 32'sd0}));
    // round-trip extremes and offset extremes
    directed.push_back(item_row(exchange(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h7FFF)));
    directed.push_back(item_row(exchange(32'h1234_5678, 32'h8000_0000, 32'h9ABC_DEF0, 32'h0,
                                         16'h8000)));
    directed.push_back(item_row(exchange(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 16'h7FFF)));
    directed.push_back(item_row(exchange(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000,
                                         16'h8000)));
    // about 10 m with wrapping timestamps, fills the window
    directed.push_back(item_row(exchange(32'hFFFF_0000, 32'd104262, 32'h4000_0000, 32'd100000,
                                         16'd120)));
    directed.push_back(item_row(exchange(32'hFFFF_FF00, 32'd104270, 32'hFFFF_FFF0, 32'd100000,
                                         16'hFF00)));
    directed.push_back(item_row(exchange(32'h8000_0000, 32'd104250, 32'h0000_1000, 32'd100000,
                                         16'd5)));
    directed.push_back(item_row(exchange(32'h0000_0010, 32'd104266, 32'h7FFF_FFF0, 32'd100000,
                                         16'hFFF0)));
    // full window: near sample passes the gate, far one is held back
    directed.push_back(item_row(exchange(32'h0101_0101, 32'd104266, 32'h0202_0202, 32'd100000,
                                         16'd0)));
    directed.push_back(item_row(exchange(32'h0303_0303, 32'd142620, 32'h0404_0404, 32'd100000,
                                         16'd0)));
    // zero error limit: next rejection restarts the window fill
    directed.push_back(settings_row(dstrf_pkg::MPT_RESET, dstrf_pkg::GATE_RESET, 32'd0));
    directed.push_back(item_row(exchange(32'h0505_0505, 32'd142620, 32'h0606_0606, 32'd100000,
                                         16'd0)));
    directed.push_back(item_row(exchange(32'h0707_0707, 32'd104262, 32'h0808_0808, 32'd100000,
                                         16'd0)));
    directed.push_back(settings_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF));
    directed.push_back(item_row(exchange(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 16'h8000)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_setting)
        apply_settings(directed[i].mpt, directed[i].gate, directed[i].limit);
      else
        send_item(directed[i].x, directed[i].typed, directed[i].want);
    end

    run_phase(dstrf_pkg::MPT_RESET, dstrf_pkg::GATE_RESET, dstrf_pkg::LIMIT_RESET, 150, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd255, 80, 1'b0);
    run_phase(32'd0, 32'd0, 32'd0, 60, 1'b0);
    run_phase(dstrf_pkg::MPT_RESET, 32'd65536, 32'd3, 150, 1'b0);
    for (p = 0; p < 3; p++) run_phase($urandom, $urandom, $urandom, 60, 1'b0);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    run_phase(dstrf_pkg::MPT_RESET, 32'd327680, 32'd5, 200, 1'b0);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("%0d exchanges over %0d register settings, %0d results compared",
             items_sent, settings_applied, results_checked);
    $display("%0d gate rejections, %0d window restarts, %0d mismatches",
             rejections_seen, restarts_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ ds_twr_range_filter.f @@
hdl/dstrf_pkg.sv
hdl/dstrf_smul.sv
hdl/dstrf_sdiv.sv
hdl/ds_twr_range_filter.sv
test/tb.sv
